// File: hw/rtl/isfe_pkg.sv
// ----------------------------------------------------------------------------
// isfe_pkg
// Shared types, constants and fixed-point helpers of the serendipity shape
// function evaluator.
// ----------------------------------------------------------------------------
package isfe_pkg;

	localparam int FRAC = 16;
	localparam int CW   = FRAC + 2;
	localparam int IW   = FRAC + 9;
	localparam int PW   = 2 * IW;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [IW-1:0] fx_t;

	localparam fx_t ONE = fx_t'(1) <<< FRAC;

	localparam logic [2:0] KIND_QUAD8  = 3'd0;
	localparam logic [2:0] KIND_QUAD12 = 3'd1;
	localparam logic [2:0] KIND_HEX8   = 3'd2;
	localparam logic [2:0] KIND_HEX20  = 3'd3;
	localparam logic [2:0] KIND_LAYER  = 3'd4;

	// corner sign tables, bit i set means the minus side
	localparam logic [7:0] CORNER_R = 8'b0110_0110;
	localparam logic [7:0] CORNER_S = 8'b1100_1100;
	localparam logic [7:0] CORNER_T = 8'b1111_0000;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] node;
		logic       last;
		coord_t     r;
		coord_t     s;
		coord_t     t;
	} issue_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] node;
		logic       last;
	} ctl_t;

	function automatic logic [4:0] node_count(input logic [2:0] kind);
		logic [4:0] n;
		case (kind)
			KIND_QUAD8:  n = 5'd8;
			KIND_QUAD12: n = 5'd12;
			KIND_HEX8:   n = 5'd8;
			KIND_HEX20:  n = 5'd20;
			KIND_LAYER:  n = 5'd16;
			default:     n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic coord_t clamp(input coord_t v);
		coord_t one_c;
		coord_t res;
		one_c = coord_t'(1) <<< FRAC;
		if (v > one_c) begin
			res = one_c;
		end else if (v < -one_c) begin
			res = -one_c;
		end else begin
			res = v;
		end
		return res;
	endfunction

	// product rounded to nearest, ties away from zero
	function automatic fx_t qmul(input fx_t a, input fx_t b);
		logic signed [PW-1:0] p;
		logic [PW-1:0] m;
		logic [PW-1:0] rr;
		p  = PW'(a) * PW'(b);
		m  = p[PW-1] ? PW'(-p) : PW'(p);
		rr = (m + (PW'(1) << (FRAC - 1))) >> FRAC;
		return p[PW-1] ? -fx_t'(rr[IW-1:0]) : fx_t'(rr[IW-1:0]);
	endfunction

	function automatic fx_t rdiv(input fx_t a, input logic [2:0] k);
		logic [IW-1:0] m;
		logic [IW-1:0] rr;
		m  = a[IW-1] ? IW'(-a) : IW'(a);
		rr = (m + (IW'(1) << (k - 3'd1))) >> k;
		return a[IW-1] ? -fx_t'(rr) : fx_t'(rr);
	endfunction

	function automatic fx_t sgn(input fx_t a, input logic neg);
		return neg ? -a : a;
	endfunction

	function automatic coord_t sat(input fx_t a);
		coord_t res;
		if (a > fx_t'({1'b0, {(CW-1){1'b1}}})) begin
			res = {1'b0, {(CW-1){1'b1}}};
		end else if (a < -fx_t'({1'b1, {(CW-1){1'b0}}})) begin
			res = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res = a[CW-1:0];
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/isfe_seq.sv
// ----------------------------------------------------------------------------
// isfe_seq
// Takes input transactions and the element kind, then issues one node per
// cycle into the evaluation pipeline while the pipeline advances (adv).
// ----------------------------------------------------------------------------
module isfe_seq import isfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_data,
	output logic                 iss_valid,
	output issue_t               iss
);

	logic [2:0] kind_q;
	logic       busy_q;
	logic [4:0] node_q;
	logic [4:0] cnt_q;
	logic [2:0] ikind_q;
	coord_t     r_q;
	coord_t     s_q;
	coord_t     t_q;
	logic       at_end;

	assign cfg_ready = 1'b1;
	assign at_end    = (node_q == cnt_q - 5'd1);
	assign s_tready  = adv && (!busy_q || at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_QUAD8;
		end else if (cfg_valid) begin
			kind_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			node_q <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			if (busy_q && !at_end) begin
				node_q <= node_q + 5'd1;
			end else if (s_tvalid) begin
				busy_q <= (node_count(kind_q) != 5'd0);
				cnt_q  <= node_count(kind_q);
				node_q <= '0;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ikind_q <= kind_q;
			r_q     <= clamp(s_tdata[CW-1:0]);
			s_q     <= clamp(s_tdata[2*CW-1:CW]);
			t_q     <= clamp(s_tdata[3*CW-1:2*CW]);
		end
	end

	assign iss_valid = busy_q;
	assign iss.kind  = ikind_q;
	assign iss.node  = node_q;
	assign iss.last  = at_end;
	assign iss.r     = r_q;
	assign iss.s     = s_q;
	assign iss.t     = t_q;

endmodule

// File: hw/rtl/isfe_datapath.sv
// ----------------------------------------------------------------------------
// isfe_datapath
// Seven-stage pipeline that evaluates one node's shape function per cycle while adv is high.
// ----------------------------------------------------------------------------
module isfe_datapath import isfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 iss_valid,
	input  issue_t               iss,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	logic [7:1] v_q;
	ctl_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7;

	// stage 1: squares and cross products
	fx_t r_s1, s_s1, t_s1, r2_s1, s2_s1, t2_s1, rs_s1, rt_s1, st_s1;
	// stage 2: derived factors
	fx_t r_s2, s_s2, t_s2, rs_s2, rt_s2, st_s2, rst_s2;
	fx_t rqm_s2, sqm_s2, tqm_s2, a_s2;
	// stage 3: operand select
	fx_t x_s3 [4];
	fx_t y_s3 [4];
	fx_t z_s3 [4];
	logic [3:0] n_s3;
	fx_t base_s3, scl_s3;
	logic m9_s3;
	logic [2:0] sh_s3;
	// stage 4/5: products
	fx_t p_s4 [4];
	fx_t z_s4 [4];
	fx_t q_s5 [4];
	logic [3:0] n_s4, n_s5;
	fx_t base_s4, base_s5, scl_s4, scl_s5, scl_s6;
	logic m9_s4, m9_s5;
	logic [2:0] sh_s4, sh_s5;
	// stage 6/7
	fx_t v_s6;
	coord_t val_s7;

	fx_t x_c [4];
	fx_t y_c [4];
	fx_t z_c [4];
	logic [3:0] n_c;
	fx_t base_c, scl_c;
	logic m9_c;
	logic [2:0] sh_c;
	fx_t tot6, tot9, w7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[6:1], iss_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1  <= '{kind: iss.kind, node: iss.node, last: iss.last};
			r_s1  <= fx_t'(iss.r);
			s_s1  <= fx_t'(iss.s);
			t_s1  <= fx_t'(iss.t);
			r2_s1 <= qmul(fx_t'(iss.r), fx_t'(iss.r));
			s2_s1 <= qmul(fx_t'(iss.s), fx_t'(iss.s));
			t2_s1 <= qmul(fx_t'(iss.t), fx_t'(iss.t));
			rs_s1 <= qmul(fx_t'(iss.r), fx_t'(iss.s));
			rt_s1 <= qmul(fx_t'(iss.r), fx_t'(iss.t));
			st_s1 <= qmul(fx_t'(iss.s), fx_t'(iss.t));

			c_s2   <= c_s1;
			r_s2   <= r_s1;
			s_s2   <= s_s1;
			t_s2   <= t_s1;
			rs_s2  <= rs_s1;
			rt_s2  <= rt_s1;
			st_s2  <= st_s1;
			rst_s2 <= qmul(rs_s1, t_s1);
			rqm_s2 <= ONE - r2_s1;
			sqm_s2 <= ONE - s2_s1;
			tqm_s2 <= ONE - t2_s1;
			a_s2   <= (r2_s1 <<< 3) + r2_s1 + (s2_s1 <<< 3) + s2_s1 - (ONE <<< 3) - (ONE <<< 1);

			c_s3    <= c_s2;
			x_s3    <= x_c;
			y_s3    <= y_c;
			z_s3    <= z_c;
			n_s3    <= n_c;
			base_s3 <= base_c;
			scl_s3  <= scl_c;
			m9_s3   <= m9_c;
			sh_s3   <= sh_c;

			c_s4    <= c_s3;
			for (int i = 0; i < 4; i++) begin
				p_s4[i] <= qmul(x_s3[i], y_s3[i]);
				z_s4[i] <= z_s3[i];
			end
			n_s4    <= n_s3;
			base_s4 <= base_s3;
			scl_s4  <= scl_s3;
			m9_s4   <= m9_s3;
			sh_s4   <= sh_s3;

			c_s5    <= c_s4;
			for (int i = 0; i < 4; i++) begin
				q_s5[i] <= qmul(p_s4[i], z_s4[i]);
			end
			n_s5    <= n_s4;
			base_s5 <= base_s4;
			scl_s5  <= scl_s4;
			m9_s5   <= m9_s4;
			sh_s5   <= sh_s4;

			c_s6   <= c_s5;
			v_s6   <= rdiv(tot9, sh_s5);
			scl_s6 <= scl_s5;

			c_s7   <= c_s6;
			val_s7 <= sat(w7);
		end
	end

	// operand select for the node's terms
	always_comb begin
		fx_t rp, rm, sp, sm, tp, tm, rp3, rm3, sp3, sm3, cr, cs, ct;
		logic [4:0] j;
		logic [2:0] qj;
		logic [4:0] hj;
		rp  = ONE + r_s2;
		rm  = ONE - r_s2;
		sp  = ONE + s_s2;
		sm  = ONE - s_s2;
		tp  = ONE + t_s2;
		tm  = ONE - t_s2;
		rp3 = ONE + (r_s2 <<< 1) + r_s2;
		rm3 = ONE - (r_s2 <<< 1) - r_s2;
		sp3 = ONE + (s_s2 <<< 1) + s_s2;
		sm3 = ONE - (s_s2 <<< 1) - s_s2;
		j   = c_s2.node;
		qj  = j[2:0];
		hj  = j - 5'd8;
		cr  = CORNER_R[qj] ? rm : rp;
		cs  = CORNER_S[qj] ? sm : sp;
		ct  = CORNER_T[qj] ? tm : tp;
		for (int i = 0; i < 4; i++) begin
			x_c[i] = '0;
			y_c[i] = '0;
			z_c[i] = ONE;
		end
		n_c    = '0;
		base_c = '0;
		scl_c  = rdiv(j[3] ? tm : tp, 3'd1);
		m9_c   = 1'b0;
		sh_c   = 3'd1;
		case (c_s2.kind)
			KIND_QUAD8, KIND_LAYER: begin
				case (qj)
					3'd4: begin x_c[0] = rqm_s2; y_c[0] = sp; end
					3'd5: begin x_c[0] = sqm_s2; y_c[0] = rm; end
					3'd6: begin x_c[0] = rqm_s2; y_c[0] = sm; end
					3'd7: begin x_c[0] = sqm_s2; y_c[0] = rp; end
					default: begin
						x_c[0] = cr;     y_c[0] = cs;
						x_c[1] = rqm_s2; y_c[1] = cs;
						x_c[2] = sqm_s2; y_c[2] = cr;
						n_c    = 4'b0110;
						sh_c   = 3'd2;
					end
				endcase
			end
			KIND_QUAD12: begin
				sh_c = 3'd5;
				m9_c = 1'b1;
				case (j)
					5'd4:  begin x_c[0] = sp; y_c[0] = rqm_s2; z_c[0] = rp3; end
					5'd5:  begin x_c[0] = sp; y_c[0] = rqm_s2; z_c[0] = rm3; end
					5'd6:  begin x_c[0] = rm; y_c[0] = sqm_s2; z_c[0] = sp3; end
					5'd7:  begin x_c[0] = rm; y_c[0] = sqm_s2; z_c[0] = sm3; end
					5'd8:  begin x_c[0] = sm; y_c[0] = rqm_s2; z_c[0] = rm3; end
					5'd9:  begin x_c[0] = sm; y_c[0] = rqm_s2; z_c[0] = rp3; end
					5'd10: begin x_c[0] = rp; y_c[0] = sqm_s2; z_c[0] = sm3; end
					5'd11: begin x_c[0] = rp; y_c[0] = sqm_s2; z_c[0] = sp3; end
					default: begin
						x_c[0] = cr; y_c[0] = cs; z_c[0] = a_s2;
						m9_c   = 1'b0;
					end
				endcase
			end
			KIND_HEX8: begin
				sh_c   = 3'd3;
				base_c = ONE + sgn(r_s2, CORNER_R[qj]) + sgn(s_s2, CORNER_S[qj])
					+ sgn(rs_s2, CORNER_R[qj] ^ CORNER_S[qj]) + sgn(t_s2, CORNER_T[qj])
					+ sgn(rt_s2, CORNER_R[qj] ^ CORNER_T[qj])
					+ sgn(st_s2, CORNER_S[qj] ^ CORNER_T[qj])
					+ sgn(rst_s2, CORNER_R[qj] ^ CORNER_S[qj] ^ CORNER_T[qj]);
			end
			KIND_HEX20: begin
				sh_c = 3'd2;
				if (j < 5'd8) begin
					sh_c   = 3'd3;
					x_c[0] = cr;     y_c[0] = cs;     z_c[0] = ct;
					x_c[1] = rqm_s2; y_c[1] = cs;     z_c[1] = ct;
					x_c[2] = cr;     y_c[2] = sqm_s2; z_c[2] = ct;
					x_c[3] = cr;     y_c[3] = cs;     z_c[3] = tqm_s2;
					n_c    = 4'b1110;
				end else if (j < 5'd16) begin
					z_c[0] = hj[2] ? tm : tp;
					case (hj[1:0])
						2'd0:    begin x_c[0] = rqm_s2; y_c[0] = sp; end
						2'd1:    begin x_c[0] = rm; y_c[0] = sqm_s2; end
						2'd2:    begin x_c[0] = rqm_s2; y_c[0] = sm; end
						default: begin x_c[0] = rp; y_c[0] = sqm_s2; end
					endcase
				end else begin
					z_c[0] = tqm_s2;
					case (j[1:0])
						2'd0:    begin x_c[0] = rp; y_c[0] = sp; end
						2'd1:    begin x_c[0] = rm; y_c[0] = sp; end
						2'd2:    begin x_c[0] = rm; y_c[0] = sm; end
						default: begin x_c[0] = rp; y_c[0] = sm; end
					endcase
				end
			end
			default: begin
				sh_c = 3'd1;
			end
		endcase
	end

	assign tot6 = base_s5 + sgn(q_s5[0], n_s5[0]) + sgn(q_s5[1], n_s5[1])
		+ sgn(q_s5[2], n_s5[2]) + sgn(q_s5[3], n_s5[3]);
	assign tot9 = m9_s5 ? (tot6 <<< 3) + tot6 : tot6;
	assign w7   = (c_s6.kind == KIND_LAYER) ? qmul(v_s6, scl_s6) : v_s6;

	assign m_tvalid = v_q[7];
	assign m_tdata  = {1'b0, val_s7, c_s7.node + 5'd1};
	assign m_tlast  = c_s7.last;

endmodule

// File: hw/rtl/isoparametric_shape_function_eval.sv
// ----------------------------------------------------------------------------
// isoparametric_shape_function_eval
// Serendipity shape function evaluator: one point in, one value per node out.
// ----------------------------------------------------------------------------
// Each input transaction carries one point (r, s, t) in natural coordinates,
// Q2.16, clamped to [-1, 1]. The block answers with one output transaction per
// node of the element kind held in the configuration register (0 quad8,
// 1 quad12, 2 hex8, 3 hex20, 4 sixteen-node layered quad; 5..7 give nothing),
// in node order, tlast on the final node. A point occupies the node issuer until
// all of the element's nodes (8, 12, 16 or 20) have issued, one node per cycle
// while the output is not stalled; the next point is taken in the cycle its
// predecessor's last node issues.
// Write the element kind only while the block is idle.
module isoparametric_shape_function_eval import isfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // coord_r, coord_s, coord_t
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // node_number, shape_value
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_data
);

	logic   adv;
	logic   iss_valid;
	issue_t iss;

	assign adv = !m_tvalid || m_tready;

	isfe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.iss_valid (iss_valid),
		.iss       (iss)
	);

	isfe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.iss_valid (iss_valid),
		.iss       (iss),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
